// ===== sv/skrf_pkg.sv =====
// ----------------------------------------------------------------------------
// skrf_pkg
// Shared widths, codes, reset values and state type for the scalar Kalman
// yaw-rate filter.
// ----------------------------------------------------------------------------
package skrf_pkg;

  // Fixed-point format of every rate and variance.
  localparam int FRACTION_BITS = 16;

  localparam int RATE_W     = 32;
  localparam int VAR_W      = 32;
  localparam int WIDE_W     = RATE_W + 1;
  localparam int PROD_W     = VAR_W + WIDE_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_MOTION_NOISE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_NOISE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_VAR    = 2'd2;

  typedef enum logic {
    OP_GYRO = 1'b0,
    OP_ODOM = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOTION,
    ST_MEAN,
    ST_SETUP,
    ST_START,
    ST_MUL,
    ST_DIV,
    ST_APPLY,
    ST_EMIT_STATE
  } state_t;

  // Saturates a scaled constant into an unsigned variance word.
  function automatic logic [VAR_W-1:0] sat_var(input longint unsigned v);
    logic [VAR_W-1:0] res;
    if (v > 64'hFFFF_FFFF) begin
      res = '1;
    end else begin
      res = VAR_W'(v);
    end
    return res;
  endfunction

  // Reset values: 4.0, 0.5 and 1000.0 in the fixed-point format.
  localparam logic [VAR_W-1:0] MOTION_NOISE_RST = sat_var((64'd8 << FRACTION_BITS) >> 1);
  localparam logic [VAR_W-1:0] SENSOR_NOISE_RST = sat_var((64'd1 << FRACTION_BITS) >> 1);
  localparam logic [VAR_W-1:0] INITIAL_VAR_RST  = sat_var((64'd2000 << FRACTION_BITS) >> 1);

endpackage

// ===== sv/skrf_in_if.sv =====
// ----------------------------------------------------------------------------
// skrf_in_if
// Sample channel: opcode and rate sample with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface skrf_in_if import skrf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  op_t                      opcode;
  logic signed [RATE_W-1:0] rate_sample;

  modport source (output valid, output opcode, output rate_sample, input ready);
  modport sink   (input valid, input opcode, input rate_sample, output ready);
endinterface

// ===== sv/skrf_out_if.sv =====
// ----------------------------------------------------------------------------
// skrf_out_if
// Result channel: filtered rate with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface skrf_out_if import skrf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [RATE_W-1:0] filtered_rate;

  modport source (output valid, output filtered_rate, input ready);
  modport sink   (input valid, input filtered_rate, output ready);
endinterface

// ===== sv/skrf_cfg_if.sv =====
// ----------------------------------------------------------------------------
// skrf_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface skrf_cfg_if import skrf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/skrf_mul.sv =====
// ----------------------------------------------------------------------------
// skrf_mul
// Bit-serial shift-add multiplier computing a * b + addend, one multiplier
// bit per cycle.
// ----------------------------------------------------------------------------
module skrf_mul import skrf_pkg::*; #(
  parameter int A_W = VAR_W,
  parameter int B_W = WIDE_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [A_W-1:0]   a,
  input  logic [B_W-1:0]   b,
  input  logic [A_W-1:0]   addend,
  output logic             done,
  output logic [A_W+B_W-1:0] product
);

  localparam int CNT_W = $clog2(B_W + 1);

  logic [A_W-1:0]   a_r, a_nxt;
  logic [A_W-1:0]   hi_r, hi_nxt;
  logic [B_W-1:0]   lo_r, lo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [A_W:0]     sum;

  // The addend starts in the high half, where it carries weight one once
  // all multiplier bits have been shifted through.
  always_comb begin
    sum      = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);
    a_nxt    = a_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt   = a;
      hi_nxt  = addend;
      lo_nxt  = b;
      cnt_nxt = CNT_W'(B_W);
    end else if (cnt_r != '0) begin
      hi_nxt   = sum[A_W:1];
      lo_nxt   = {sum[0], lo_r[B_W-1:1]};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r  <= a_nxt;
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  assign done    = done_r;
  assign product = {hi_r, lo_r};

endmodule

// ===== sv/skrf_div.sv =====
// ----------------------------------------------------------------------------
// skrf_div
// Restoring radix-2 divider, one quotient bit per cycle. The caller
// guarantees that the quotient fits in Q_W bits.
// ----------------------------------------------------------------------------
module skrf_div import skrf_pkg::*; #(
  parameter int N_W = PROD_W,
  parameter int D_W = WIDE_W,
  parameter int Q_W = WIDE_W
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] num,
  input  logic [D_W-1:0] den,
  output logic           done,
  output logic [Q_W-1:0] quotient
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [D_W-1:0]   rem_r, rem_nxt;
  logic [D_W-1:0]   d_r, d_nxt;
  logic [Q_W-1:0]   quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [D_W:0]     part;
  logic [D_W+1:0]   trial;
  logic             fits;

  // The low numerator bits sit in the quotient register and shift into the
  // remainder as the quotient bits shift in behind them.
  always_comb begin
    part     = {rem_r, quo_r[Q_W-1]};
    trial    = {1'b0, part} - {2'b00, d_r};
    fits     = ~trial[D_W+1];
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = D_W'(num[N_W-1:Q_W]);
      quo_nxt = num[Q_W-1:0];
      d_nxt   = den;
      cnt_nxt = CNT_W'(Q_W);
    end else if (cnt_r != '0) begin
      rem_nxt  = fits ? trial[D_W-1:0] : part[D_W-1:0];
      quo_nxt  = {quo_r[Q_W-2:0], fits};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== sv/scalar_kalman_rate_filter.sv =====
// ----------------------------------------------------------------------------
// scalar_kalman_rate_filter
// One-dimensional Kalman filter for yaw rate: gyro samples are stored, the
// first odometry sample seeds it; later ones predict, update and emit.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Payload                         | Handshake
//   --------+-----------+---------------------------------+------------------
//   cfg_if  | in        | index (2 b), data (32 b)        | valid/ready
//   in_if   | in        | opcode (1 b), rate_sample (32 b)| valid/ready
//   out_if  | out       | filtered_rate (32 b signed)     | valid/ready
//
// A gyro beat and the first odometry beat are absorbed in the accept cycle
// and the block is ready again on the next cycle. Every later odometry beat
// goes through prediction and setup (MOTION, MEAN, SETUP, START), the 33-step
// bit-serial multiply, the 33-step restoring divide, then apply and emit;
// when the total variance is zero the update is skipped and the result is
// emitted straight after setup.
// Reset is synchronous and active low; it loads the configuration registers
// with 4.0, 0.5 and 1000.0 and returns the filter to its unseeded state.
// The result sits in an output register, so a new sample beat is accepted
// while a result is still waiting; a second result waits inside the block
// until the first beat has left.
//
module scalar_kalman_rate_filter import skrf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  skrf_cfg_if.sink   cfg_if,
  skrf_in_if.sink    in_if,
  skrf_out_if.source out_if
);

  // Configuration registers.
  logic [VAR_W-1:0]  mnv_r, mnv_nxt;
  logic [VAR_W-1:0]  snv_r, snv_nxt;
  logic [VAR_W-1:0]  init_r, init_nxt;

  // Filter state.
  state_t            state_r, state_nxt;
  logic [RATE_W-1:0] mean_r, mean_nxt;
  logic [VAR_W-1:0]  var_r, var_nxt;
  logic              first_r, first_nxt;
  logic [RATE_W-1:0] prev_r, prev_nxt;
  logic [RATE_W-1:0] gyro_r, gyro_nxt;

  // Working registers of one odometry step.
  logic [RATE_W-1:0] x_r, x_nxt;
  logic [WIDE_W-1:0] motion_r, motion_nxt;
  logic [WIDE_W-1:0] den_r, den_nxt;
  logic [WIDE_W-1:0] diff_r, diff_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [RATE_W-1:0] out_rate_r, out_rate_nxt;

  // Serial arithmetic units.
  logic              mul_start, div_start;
  logic              gain_mul_done, var_mul_done;
  logic              gain_div_done, var_div_done;
  logic [PROD_W-1:0] gain_prod, var_prod;
  logic [WIDE_W-1:0] corr_q, var_q;
  logic [WIDE_W-1:0] mag;

  logic              in_fire;

  assign in_fire      = in_if.valid && in_if.ready;
  assign in_if.ready  = (state_r == ST_IDLE);
  assign cfg_if.ready = 1'b1;

  // The magnitude of gyro minus mean feeds the gain multiplier at start.
  assign mag = diff_r[WIDE_W-1] ? (~diff_r + 1'b1) : diff_r;

  // Configuration writes; indexes past the register list are dropped.
  always_comb begin
    mnv_nxt  = mnv_r;
    snv_nxt  = snv_r;
    init_nxt = init_r;
    if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_MOTION_NOISE: mnv_nxt  = cfg_if.data;
        REG_SENSOR_NOISE: snv_nxt  = cfg_if.data;
        REG_INITIAL_VAR:  init_nxt = cfg_if.data;
        default: ;
      endcase
    end
  end

  // Sequencer and datapath.
  always_comb begin
    logic [WIDE_W-1:0]   var_sum;
    logic [WIDE_W:0]     mean_sum;
    logic [WIDE_W:0]     mean_ext;
    logic [WIDE_W:0]     applied;
    logic                emit;

    state_nxt     = state_r;
    mean_nxt      = mean_r;
    var_nxt       = var_r;
    first_nxt     = first_r;
    prev_nxt      = prev_r;
    gyro_nxt      = gyro_r;
    x_nxt         = x_r;
    motion_nxt    = motion_r;
    den_nxt       = den_r;
    diff_nxt      = diff_r;
    mul_start     = 1'b0;
    div_start     = 1'b0;
    emit          = 1'b0;

    var_sum  = {1'b0, var_r} + {1'b0, mnv_r};
    mean_sum = {{2{mean_r[RATE_W-1]}}, mean_r} + {motion_r[WIDE_W-1], motion_r};
    mean_ext = {{2{mean_r[RATE_W-1]}}, mean_r};
    applied  = diff_r[WIDE_W-1] ? (mean_ext - {1'b0, corr_q})
                                : (mean_ext + {1'b0, corr_q});

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_if.opcode == OP_GYRO) begin
            gyro_nxt = in_if.rate_sample;
          end else if (first_r) begin
            // The first odometry sample seeds the filter.
            mean_nxt  = in_if.rate_sample;
            prev_nxt  = in_if.rate_sample;
            var_nxt   = init_r;
            first_nxt = 1'b0;
          end else begin
            x_nxt     = in_if.rate_sample;
            state_nxt = ST_MOTION;
          end
        end
      end
      ST_MOTION: begin
        motion_nxt = {x_r[RATE_W-1], x_r} - {prev_r[RATE_W-1], prev_r};
        var_nxt    = var_sum[VAR_W] ? '1 : var_sum[VAR_W-1:0];
        state_nxt  = ST_MEAN;
      end
      ST_MEAN: begin
        // Saturate the predicted mean to the signed range.
        if (mean_sum[WIDE_W] != mean_sum[RATE_W-1] ||
            mean_sum[WIDE_W-1] != mean_sum[RATE_W-1]) begin
          mean_nxt = {mean_sum[WIDE_W], {(RATE_W-1){~mean_sum[WIDE_W]}}};
        end else begin
          mean_nxt = mean_sum[RATE_W-1:0];
        end
        prev_nxt  = x_r;
        state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        den_nxt   = {1'b0, var_r} + {1'b0, snv_r};
        diff_nxt  = {gyro_r[RATE_W-1], gyro_r} - {mean_r[RATE_W-1], mean_r};
        state_nxt = ST_START;
      end
      ST_START: begin
        // With zero total variance the update leaves mean and variance alone.
        if (den_r == '0) begin
          state_nxt = ST_EMIT_STATE;
        end else begin
          mul_start = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (gain_mul_done && var_mul_done) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (gain_div_done && var_div_done) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        // The correction never carries the mean past the gyro value.
        mean_nxt  = applied[RATE_W-1:0];
        var_nxt   = var_q[VAR_W-1:0];
        state_nxt = ST_EMIT_STATE;
      end
      ST_EMIT_STATE: begin
        emit = !out_valid_r || out_if.ready;
        if (emit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_rate_nxt  = mean_r;
    end else begin
      out_valid_nxt = out_valid_r && !out_if.ready;
      out_rate_nxt  = out_rate_r;
    end
  end

  // Gain numerator v*|g - mean| + den/2 and variance numerator v*s + den/2,
  // both built bit-serially in parallel.
  skrf_mul #(.A_W(VAR_W), .B_W(WIDE_W)) u_gain_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (var_r),
    .b       (mag),
    .addend  (den_r[WIDE_W-1:1]),
    .done    (gain_mul_done),
    .product (gain_prod)
  );

  skrf_mul #(.A_W(VAR_W), .B_W(WIDE_W)) u_var_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (var_r),
    .b       ({1'b0, snv_r}),
    .addend  (den_r[WIDE_W-1:1]),
    .done    (var_mul_done),
    .product (var_prod)
  );

  // Both quotients stay below 2^33 because v <= v + s.
  skrf_div #(.N_W(PROD_W), .D_W(WIDE_W), .Q_W(WIDE_W)) u_gain_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num      (gain_prod),
    .den      (den_r),
    .done     (gain_div_done),
    .quotient (corr_q)
  );

  skrf_div #(.N_W(PROD_W), .D_W(WIDE_W), .Q_W(WIDE_W)) u_var_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num      (var_prod),
    .den      (den_r),
    .done     (var_div_done),
    .quotient (var_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mnv_r       <= MOTION_NOISE_RST;
      snv_r       <= SENSOR_NOISE_RST;
      init_r      <= INITIAL_VAR_RST;
      state_r     <= ST_IDLE;
      mean_r      <= '0;
      var_r       <= INITIAL_VAR_RST;
      first_r     <= 1'b1;
      prev_r      <= '0;
      gyro_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mnv_r       <= mnv_nxt;
      snv_r       <= snv_nxt;
      init_r      <= init_nxt;
      state_r     <= state_nxt;
      mean_r      <= mean_nxt;
      var_r       <= var_nxt;
      first_r     <= first_nxt;
      prev_r      <= prev_nxt;
      gyro_r      <= gyro_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    motion_r   <= motion_nxt;
    den_r      <= den_nxt;
    diff_r     <= diff_nxt;
    out_rate_r <= out_rate_nxt;
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.filtered_rate = out_rate_r;

endmodule
